// File: rtl/trk_pkg.sv
// Package for the trickle timer: time width, register map, input kinds
// and reset values. No dependencies; every other file imports it.
package trk_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int OFFSET_W   = 31;
  localparam int COUNT_W    = 32;
  localparam int HEARD_W    = 8;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef logic [TIME_WIDTH-1:0] time_t;

  localparam time_t TIME_MAX = {TIME_WIDTH{1'b1}};

  localparam logic [31:0]        RST_INTERVAL_MIN = 32'd1000;
  localparam logic [31:0]        RST_INTERVAL_MAX = 32'd60000;
  localparam logic [HEARD_W-1:0] RST_REDUNDANCY   = 8'd2;
  localparam logic               RST_ENABLE       = 1'b1;

  typedef enum logic [1:0] {
    KIND_TICK         = 2'd0,
    KIND_START        = 2'd1,
    KIND_CONSISTENT   = 2'd2,
    KIND_INCONSISTENT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_INTERVAL_MIN = 2'd0,
    REG_INTERVAL_MAX = 2'd1,
    REG_REDUNDANCY   = 2'd2,
    REG_ENABLE       = 2'd3
  } cfg_reg_t;

endpackage

// File: rtl/trk_if.sv
// Handshake channels of the trickle timer: event words in, result words out.
// Depends on trk_pkg for field widths.
interface trk_item_if import trk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [OFFSET_W-1:0] random_offset;

  modport source (output valid, kind, random_offset, input ready);
  modport sink   (input valid, kind, random_offset, output ready);
endinterface

interface trk_result_if import trk_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               transmit;
  logic               suppressed;
  logic [31:0]        interval_now;
  logic               at_max;
  logic [COUNT_W-1:0] transmit_total;
  logic [COUNT_W-1:0] suppress_total;

  modport source (output valid, transmit, suppressed, interval_now, at_max,
                  transmit_total, suppress_total, input ready);
  modport sink   (input valid, transmit, suppressed, interval_now, at_max,
                  transmit_total, suppress_total, output ready);
endinterface

// File: rtl/trickle_timer_unit.sv
// Trickle timer top level: input register, single-pass state update, result register.
// Depends on trk_pkg and the channel interfaces in trk_if.sv.
//
//  channel  | direction | word
//  ---------+-----------+---------------------------------------------------
//  item     | in        | kind, random_offset (one tick or event per word)
//  result   | out       | transmit, suppressed, interval_now, at_max, totals
//  apb      | in        | interval_min, interval_max, redundancy, enable
//
// Each word waits in the input register and is then folded into the timer
// state, landing in the result register; one word per cycle is sustained while
// results are taken. The result register is the only point of backpressure:
// while a result waits, the input register holds one more word. Reset (rst,
// synchronous) clears the timer state and loads the register reset values.
module trickle_timer_unit import trk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  trk_item_if.sink              item,
  trk_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration registers.
  logic [31:0]        interval_min;
  logic [31:0]        interval_max;
  logic [HEARD_W-1:0] redundancy;
  logic               enable;

  // Timer state.
  logic               running;
  time_t              interval_len;
  time_t              elapsed;
  time_t              fire_point;
  logic               fire_pending;
  logic [HEARD_W-1:0] heard_count;
  logic [COUNT_W-1:0] tx_counter;
  logic [COUNT_W-1:0] sup_counter;

  // Input register.
  logic                in_valid;
  kind_t               in_kind;
  logic [OFFSET_W-1:0] in_offset;

  // Result register.
  logic res_valid;
  logic res_transmit;
  logic res_suppressed;
  logic res_at_max;

  logic advance;
  logic cfg_write;
  cfg_reg_t cfg_sel;

  // Next-state logic.
  time_t              imin, imax;
  time_t              elapsed_inc;
  logic [TIME_WIDTH:0] dbl_wide;
  time_t              dbl_sat, dbl_len;
  logic               do_restart, do_expire, do_fire, do_suppress;
  time_t              new_len, half, half_m1, off_sel, new_fire;
  logic [31:0]        off_ext;

  logic               running_next;
  time_t              interval_len_next, elapsed_next, fire_point_next;
  logic               fire_pending_next;
  logic [HEARD_W-1:0] heard_count_next;
  logic [COUNT_W-1:0] tx_counter_next, sup_counter_next;
  logic               tx_next, sup_next;

  assign advance   = in_valid && (!res_valid || result.ready);
  assign item.ready = !in_valid || advance;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    unique case (cfg_sel)
      REG_INTERVAL_MIN: prdata = interval_min;
      REG_INTERVAL_MAX: prdata = interval_max;
      REG_REDUNDANCY:   prdata = {{(CFG_DATA_W-HEARD_W){1'b0}}, redundancy};
      REG_ENABLE:       prdata = {{(CFG_DATA_W-1){1'b0}}, enable};
      default:          prdata = '0;
    endcase
  end

  assign imin = interval_min[TIME_WIDTH-1:0];
  assign imax = interval_max[TIME_WIDTH-1:0];

  assign elapsed_inc = (elapsed == TIME_MAX) ? elapsed : elapsed + time_t'(1);

  // Doubling saturates at the top of the time range, then at interval_max.
  assign dbl_wide = {interval_len, 1'b0};
  assign dbl_sat  = dbl_wide[TIME_WIDTH] ? TIME_MAX : dbl_wide[TIME_WIDTH-1:0];
  assign dbl_len  = (dbl_sat > imax) ? imax : dbl_sat;

  assign do_restart  = enable && (in_kind == KIND_START || in_kind == KIND_INCONSISTENT);
  assign do_expire   = enable && in_kind == KIND_TICK && running &&
                       (elapsed_inc >= interval_len);
  assign do_fire     = enable && in_kind == KIND_TICK && running && !do_expire &&
                       fire_pending && (elapsed_inc >= fire_point);
  assign do_suppress = (redundancy != '0) && (heard_count >= redundancy);

  // Transmit point of a new interval: half the length plus the offset,
  // the offset held below half.
  assign new_len = do_restart ? imin : dbl_len;
  assign half    = new_len >> 1;
  assign half_m1 = half - time_t'(1);
  assign off_ext = {1'b0, in_offset};
  always_comb begin
    if (half == '0) begin
      off_sel = '0;
    end else if (off_ext > 32'(half_m1)) begin
      off_sel = half_m1;
    end else begin
      off_sel = off_ext[TIME_WIDTH-1:0];
    end
  end
  assign new_fire = half + off_sel;

  always_comb begin
    running_next      = running;
    interval_len_next = interval_len;
    elapsed_next      = elapsed;
    fire_point_next   = fire_point;
    fire_pending_next = fire_pending;
    heard_count_next  = heard_count;
    tx_counter_next   = tx_counter;
    sup_counter_next  = sup_counter;
    tx_next           = 1'b0;
    sup_next          = 1'b0;
    if (!enable) begin
      tx_next = (in_kind == KIND_TICK);
    end else if (do_restart || do_expire) begin
      running_next      = running || do_restart;
      interval_len_next = new_len;
      elapsed_next      = '0;
      heard_count_next  = '0;
      fire_point_next   = new_fire;
      fire_pending_next = 1'b1;
    end else if (in_kind == KIND_CONSISTENT) begin
      if (heard_count != {HEARD_W{1'b1}}) begin
        heard_count_next = heard_count + HEARD_W'(1);
      end
    end else if (running) begin
      elapsed_next = elapsed_inc;
      if (do_fire) begin
        fire_pending_next = 1'b0;
        if (do_suppress) begin
          sup_next         = 1'b1;
          sup_counter_next = sup_counter + COUNT_W'(1);
        end else begin
          tx_next         = 1'b1;
          tx_counter_next = tx_counter + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_min <= RST_INTERVAL_MIN;
      interval_max <= RST_INTERVAL_MAX;
      redundancy   <= RST_REDUNDANCY;
      enable       <= RST_ENABLE;
      running      <= 1'b0;
      interval_len <= RST_INTERVAL_MIN[TIME_WIDTH-1:0];
      elapsed      <= '0;
      fire_point   <= '0;
      fire_pending <= 1'b0;
      heard_count  <= '0;
      tx_counter   <= '0;
      sup_counter  <= '0;
      in_valid     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_sel)
          REG_INTERVAL_MIN: interval_min <= pwdata;
          REG_INTERVAL_MAX: interval_max <= pwdata;
          REG_REDUNDANCY:   redundancy   <= pwdata[HEARD_W-1:0];
          REG_ENABLE:       enable       <= pwdata[0];
          default:          ;
        endcase
      end
      if (item.valid && item.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        running      <= running_next;
        interval_len <= interval_len_next;
        elapsed      <= elapsed_next;
        fire_point   <= fire_point_next;
        fire_pending <= fire_pending_next;
        heard_count  <= heard_count_next;
        tx_counter   <= tx_counter_next;
        sup_counter  <= sup_counter_next;
        res_valid    <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_kind   <= kind_t'(item.kind);
      in_offset <= item.random_offset;
    end
    if (advance) begin
      res_transmit   <= tx_next;
      res_suppressed <= sup_next;
      res_at_max     <= (interval_len_next >= imax);
    end
  end

  assign result.valid          = res_valid;
  assign result.transmit       = res_transmit;
  assign result.suppressed     = res_suppressed;
  assign result.interval_now   = 32'(interval_len);
  assign result.at_max         = res_at_max;
  assign result.transmit_total = tx_counter;
  assign result.suppress_total = sup_counter;

`ifndef ASSERT_OFF
  a_fire_in_interval: assert property (@(posedge clk) disable iff (rst)
    fire_point <= interval_len)
    else $error("transmit point lies beyond the interval");

  a_tx_xor_sup: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_transmit && res_suppressed))
    else $error("result both transmits and suppresses");

  a_sup_count: assert property (@(posedge clk) disable iff (rst)
    (advance && !rst) |=>
      sup_counter == $past(sup_counter) + COUNT_W'(res_suppressed))
    else $error("suppress total out of step with suppressed results");

  a_tx_count: assert property (@(posedge clk) disable iff (rst)
    (advance && !rst && enable) |=>
      tx_counter == $past(tx_counter) + COUNT_W'(res_transmit))
    else $error("transmit total out of step with transmit results");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (in_valid && res_valid && !result.ready))
    else $error("input stalled without a waiting result");
`endif

endmodule

// File: verif/trickle_timer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for trickle_timer_unit: drives ticks and hellos, predicts every
// result word and checks it. Depends on trk_pkg, the channels in trk_if.sv and the RTL.
module trickle_timer_unit_tb;
  import trk_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic        transmit;
    logic        suppressed;
    time_t       interval_now;
    logic        at_max;
    logic [31:0] transmit_total;
    logic [31:0] suppress_total;
  } tick_outcome_t;

  class trickle_scoreboard;
    time_t              min_len;
    time_t              max_len;
    logic [HEARD_W-1:0] redundancy;
    logic               enabled;
    logic               running;
    time_t              interval_len;
    time_t              elapsed;
    time_t              fire_at;
    logic               fire_armed;
    logic [HEARD_W-1:0] hellos;
    logic [31:0]        tx_total;
    logic [31:0]        sup_total;
    tick_outcome_t      outcome_q[$];
    int                 errors;

    function new();
      min_len      = RST_INTERVAL_MIN;
      max_len      = RST_INTERVAL_MAX;
      redundancy   = RST_REDUNDANCY;
      enabled      = RST_ENABLE;
      running      = 1'b0;
      interval_len = RST_INTERVAL_MIN;
      elapsed      = '0;
      fire_at      = '0;
      fire_armed   = 1'b0;
      hellos       = '0;
      tx_total     = '0;
      sup_total    = '0;
      errors       = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [31:0] value);
      case (r)
        REG_INTERVAL_MIN: min_len = value;
        REG_INTERVAL_MAX: max_len = value;
        REG_REDUNDANCY:   redundancy = value[HEARD_W-1:0];
        REG_ENABLE:       enabled = value[0];
        default: ;
      endcase
    endfunction

    // The offset is held below half the interval; a half of zero forces it to zero.
    function void begin_interval(time_t len, logic [OFFSET_W-1:0] offset);
      time_t half;
      time_t clip;
      half = len >> 1;
      if (half == '0)
        clip = '0;
      else if (time_t'(offset) > half - 1)
        clip = half - 1;
      else
        clip = time_t'(offset);
      interval_len = len;
      elapsed      = '0;
      hellos       = '0;
      fire_at      = half + clip;
      fire_armed   = 1'b1;
    endfunction

    function void note_event(kind_t kind, logic [OFFSET_W-1:0] offset);
      tick_outcome_t        o;
      logic [TIME_WIDTH:0]  doubled;
      o.transmit   = 1'b0;
      o.suppressed = 1'b0;
      if (!enabled) begin
        o.transmit = (kind == KIND_TICK);
      end else begin
        case (kind)
          KIND_START, KIND_INCONSISTENT: begin
            running = 1'b1;
            begin_interval(min_len, offset);
          end
          KIND_CONSISTENT: begin
            if (hellos != '1)
              hellos++;
          end
          default: begin
            if (running) begin
              if (elapsed != TIME_MAX)
                elapsed++;
              // Expiry wins over the transmit point on the same tick.
              if (elapsed >= interval_len) begin
                doubled = {interval_len, 1'b0};
                if (doubled > {1'b0, TIME_MAX})
                  doubled = {1'b0, TIME_MAX};
                if (doubled > {1'b0, max_len})
                  doubled = {1'b0, max_len};
                begin_interval(doubled[TIME_WIDTH-1:0], offset);
              end else if (fire_armed && elapsed >= fire_at) begin
                fire_armed = 1'b0;
                if (redundancy != '0 && hellos >= redundancy) begin
                  o.suppressed = 1'b1;
                  sup_total++;
                end else begin
                  o.transmit = 1'b1;
                  tx_total++;
                end
              end
            end
          end
        endcase
      end
      o.interval_now   = interval_len;
      o.at_max         = (interval_len >= max_len);
      o.transmit_total = tx_total;
      o.suppress_total = sup_total;
      outcome_q.push_back(o);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic tx, logic sup, logic [31:0] ivl, logic top,
                               logic [31:0] tx_cnt, logic [31:0] sup_cnt);
      tick_outcome_t o;
      if (outcome_q.size() == 0) begin
        $error("result word arrived with nothing expected");
        errors++;
      end else begin
        o = outcome_q.pop_front();
        compare_field("transmit", 32'(o.transmit), 32'(tx));
        compare_field("suppressed", 32'(o.suppressed), 32'(sup));
        compare_field("interval_now", 32'(o.interval_now), ivl);
        compare_field("at_max", 32'(o.at_max), 32'(top));
        compare_field("transmit_total", o.transmit_total, tx_cnt);
        compare_field("suppress_total", o.suppress_total, sup_cnt);
      end
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  trk_item_if   item_ch ();
  trk_result_if result_ch ();

  trickle_scoreboard sb = new();
  int  hold_left = 0;
  bit  steady = 1'b0;
  int  cycles = 0;

  trickle_timer_unit uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL trickle_timer_unit");
      $finish;
    end
  end

  // Result side: checks accepted words and stalls at random or on request.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        sb.check_result(result_ch.transmit, result_ch.suppressed, result_ch.interval_now,
                        result_ch.at_max, result_ch.transmit_total, result_ch.suppress_total);
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= steady || ($urandom_range(99) >= 8);
      end
    end
  end

  task automatic send_word(kind_t kind, logic [OFFSET_W-1:0] offset);
    while (!steady && $urandom_range(99) < 8) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.kind          <= kind;
    item_ch.random_offset <= offset;
    @(posedge clk);
    while (item_ch.ready !== 1'b1)
      @(posedge clk);
    sb.note_event(kind, offset);
  endtask

  // Stops offering words and waits until every expected result has come back.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(cfg_reg_t r, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1)
      @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(r, value);
  endtask

  task automatic set_config(time_t min_len, time_t max_len, logic [7:0] red, logic en);
    drain();
    apb_write(REG_INTERVAL_MIN, min_len);
    apb_write(REG_INTERVAL_MAX, max_len);
    apb_write(REG_REDUNDANCY, 32'(red));
    apb_write(REG_ENABLE, 32'(en));
  endtask

  function automatic logic [OFFSET_W-1:0] pick_offset();
    int r;
    r = $urandom_range(99);
    if (r < 50)
      return OFFSET_W'($urandom_range(7));
    else if (r < 80)
      return OFFSET_W'($urandom_range(40));
    return OFFSET_W'($urandom());
  endfunction

  // Mostly ticks, so that intervals expire and transmit points are reached.
  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 68)
      return KIND_TICK;
    else if (r < 82)
      return KIND_CONSISTENT;
    else if (r < 92)
      return KIND_INCONSISTENT;
    return KIND_START;
  endfunction

  task automatic run_phase(int words, int hold_at, int pause_at);
    for (int i = 0; i < words; i++) begin
      if (i == hold_at)
        hold_left = 60;
      if (i == pause_at)
        drain();
      send_word(pick_kind(), pick_offset());
    end
  endtask

  initial begin
    rst                   <= 1'b1;
    item_ch.valid         <= 1'b0;
    item_ch.kind          <= KIND_TICK;
    item_ch.random_offset <= '0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: idle tick, hello while idle, restart from idle, offset clamp.
    send_word(KIND_TICK, '0);
    send_word(KIND_CONSISTENT, '0);
    send_word(KIND_INCONSISTENT, 31'd7);
    send_word(KIND_START, '1);
    send_word(KIND_TICK, '1);

    // Short intervals with redundancy zero: hellos never suppress, doubling hits the cap.
    set_config(32'd2, 32'd5, 8'd0, 1'b1);
    send_word(KIND_START, '0);
    send_word(KIND_CONSISTENT, '0);
    send_word(KIND_CONSISTENT, '0);
    send_word(KIND_TICK, '0);
    send_word(KIND_TICK, '1);
    repeat (4) send_word(KIND_TICK, '0);

    // Interval of one has a half of zero; one hello is then enough to suppress.
    set_config(32'd1, 32'd8, 8'd1, 1'b1);
    send_word(KIND_START, '1);
    send_word(KIND_TICK, '1);
    send_word(KIND_CONSISTENT, '0);
    send_word(KIND_TICK, '0);
    send_word(KIND_TICK, '0);

    // Disabled: every tick transmits and events are ignored.
    set_config(32'd1, 32'd8, 8'd1, 1'b0);
    send_word(KIND_TICK, '0);
    send_word(KIND_START, '0);
    send_word(KIND_CONSISTENT, '0);

    // Zero interval expires on every tick.
    set_config(32'd0, 32'd0, 8'd1, 1'b1);
    send_word(KIND_START, '1);
    send_word(KIND_TICK, '0);
    send_word(KIND_TICK, '1);

    // More hellos than the counter holds, then the transmit point with redundancy 255.
    set_config(32'd4, 32'd4, 8'd255, 1'b1);
    send_word(KIND_START, '0);
    repeat (260) send_word(KIND_CONSISTENT, OFFSET_W'($urandom()));
    repeat (6) send_word(KIND_TICK, pick_offset());

    set_config(32'd1, 32'd32, 8'd1, 1'b1);
    run_phase(25, 15, -1);
    set_config(32'd0, 32'd0, 8'd0, 1'b1);
    run_phase(25, -1, -1);
    steady = 1'b1;
    set_config(32'd3, 32'hFFFF_FFFF, 8'd2, 1'b1);
    run_phase(25, 15, 8);
    steady = 1'b0;
    set_config(32'hFFFF_FFFF, 32'd1, 8'd255, 1'b1);
    run_phase(25, -1, -1);
    for (int p = 0; p < 2; p++) begin
      set_config($urandom_range(1, 8), $urandom_range(1, 64), 8'($urandom_range(0, 3)),
                 $urandom_range(9) != 0);
      run_phase(25, 12, -1);
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS trickle_timer_unit");
    else
      $display("FAIL trickle_timer_unit");
    $finish;
  end

endmodule
